// ===== rtl/afa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afa_pkg
// Types, codes and constants shared by the attention focus arbiter files.
// ---------------------------------------------------------------------------
package afa_pkg;

	localparam int TIME_BITS  = 32;
	localparam int CFG_BITS   = 20;
	localparam int IDX_BITS   = 3;
	localparam int CMD_BITS   = 3;
	localparam int VAL_BITS   = 16;
	localparam int FOCUS_BITS = 3;
	localparam int ENG_BITS   = 10;
	localparam int FACT_BITS  = 15;
	localparam int HOLD_BITS  = 21;
	localparam int CMP_BITS   = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

	// constant division by reciprocal multiplication: dividends below 2^RIN_BITS,
	// reciprocals scaled by 2^RECIP_SHIFT and rounded up
	localparam int PROD_BITS    = 35;
	localparam int RIN_BITS     = 30;
	localparam int RECIP_BITS   = 31;
	localparam int RECIP_SHIFT  = 40;
	localparam int RPROD_BITS   = RIN_BITS + RECIP_BITS;
	localparam int EV_PRE_SHIFT = 5;
	localparam int Q_BITS       = 21;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_BITS-1:0]  cfg_t;
	typedef logic [HOLD_BITS-1:0] hold_t;
	typedef logic [ENG_BITS-1:0]  eng_t;

	localparam cfg_t HOLD_RST       = cfg_t'(4000);
	localparam cfg_t IDLE_RET_RST   = cfg_t'(8000);
	localparam cfg_t SCAN_INT_RST   = cfg_t'(15000);
	localparam cfg_t SCAN_EXTRA_RST = cfg_t'(15000);
	localparam cfg_t IDLE_DWELL_RST = cfg_t'(3000);
	localparam cfg_t GAP_RST        = cfg_t'(300);
	localparam cfg_t INT_HOLD_RST   = cfg_t'(1500);

	localparam eng_t ENG_RST  = eng_t'(500);
	localparam eng_t ENG_FULL = eng_t'(1000);

	// event hold factor in 1/20000 units: (0.85 + 0.45 * engagement) * 20000
	localparam logic [FACT_BITS-1:0] EV_BASE  = FACT_BITS'(17000);
	localparam logic [FACT_BITS-1:0] EV_SLOPE = FACT_BITS'(9);

	// event hold divides by 20000 = 32 * 625, scan interval by 1000
	localparam logic [RECIP_BITS-1:0] RECIP_EV   = RECIP_BITS'(1759218605);
	localparam logic [RECIP_BITS-1:0] RECIP_SCAN = RECIP_BITS'(1099511628);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_TICK   = 3'd0,
		CMD_TOUCH  = 3'd1,
		CMD_VOICE  = 3'd2,
		CMD_VISION = 3'd3,
		CMD_POWER  = 3'd4,
		CMD_ENGAGE = 3'd5,
		CMD_IDLE   = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [FOCUS_BITS-1:0] {
		F_IDLE     = 3'd0,
		F_TOUCH    = 3'd1,
		F_VOICE    = 3'd2,
		F_VISION   = 3'd3,
		F_POWER    = 3'd4,
		F_INTERNAL = 3'd5
	} focus_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_HOLD       = 3'd0,
		REG_IDLE_RET   = 3'd1,
		REG_SCAN_INT   = 3'd2,
		REG_SCAN_EXTRA = 3'd3,
		REG_IDLE_DWELL = 3'd4,
		REG_GAP        = 3'd5,
		REG_INT_HOLD   = 3'd6
	} cfg_idx_t;

	typedef enum logic {
		DIV_EV   = 1'b0,
		DIV_SCAN = 1'b1
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_MUL_EV,
		S_DIV_EV_GO,
		S_DIV_EV_WAIT,
		S_MUL_SCAN,
		S_DIV_SCAN_GO,
		S_DIV_SCAN_WAIT
	} state_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]  cmd;
		logic [31:0]          now_ms;
		logic [VAL_BITS-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic                  changed;
		logic [FOCUS_BITS-1:0] focus;
		logic [31:0]           change_time;
	} out_item_t;

	typedef struct packed {
		logic     capture;
		logic     eval;
		logic     apply;
		logic     dirty_clr;
		logic     fact;
		logic     mul_ev;
		logic     mul_scan;
		logic     div_start;
		div_sel_t div_sel;
		logic     ev_load;
		logic     gap_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic dirty;
		logic div_done;
	} dp_status_t;

endpackage

// ===== rtl/afa_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afa_stream_if
// Valid/ready channel carrying one item of payload type T.
// ---------------------------------------------------------------------------
interface afa_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/afa_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afa_div
// Division by a constant through a registered reciprocal multiplication.
// ---------------------------------------------------------------------------
module afa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  afa_pkg::div_sel_t              sel,
	input  logic [afa_pkg::PROD_BITS-1:0]  dividend,
	output logic                           done,
	output logic [afa_pkg::Q_BITS-1:0]     quotient
);
	import afa_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [RIN_BITS-1:0]    num_q;
	logic [RECIP_BITS-1:0]  recip_q;
	logic [RPROD_BITS-1:0]  prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// hold product drops its five low bits first: divide by 32, then by 625
	always_ff @(posedge clk) begin
		if (start) begin
			if (sel == DIV_EV) begin
				num_q   <= dividend[PROD_BITS-1:EV_PRE_SHIFT];
				recip_q <= RECIP_EV;
			end else begin
				num_q   <= dividend[RIN_BITS-1:0];
				recip_q <= RECIP_SCAN;
			end
		end
		if (busy_q)
			prod_q <= RPROD_BITS'(num_q) * RPROD_BITS'(recip_q);
	end

	assign done     = done_q;
	assign quotient = prod_q[RECIP_SHIFT+Q_BITS-1:RECIP_SHIFT];
endmodule

// ===== rtl/afa_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afa_dp
// Datapath: settings, focus state, time compares, scaled holds, result.
// ---------------------------------------------------------------------------
module afa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afa_pkg::ctrl_cmd_t            cmd,
	output afa_pkg::dp_status_t           status,
	input  afa_pkg::in_item_t             in_item,
	output afa_pkg::out_item_t            out_item,
	input  logic                          cfg_wr_en,
	input  logic [afa_pkg::IDX_BITS-1:0]  cfg_idx,
	input  logic [afa_pkg::CFG_BITS-1:0]  cfg_wdata
);
	import afa_pkg::*;

	// settings
	cfg_t hold_q, idle_ret_q, scan_int_q, scan_extra_q, idle_dwell_q, gap_q, int_hold_q;

	// focus state
	focus_t focus_q;
	time_t  deadline_q, last_change_q, last_idle_q, last_int_q, last_scan_q;
	eng_t   eng_q;
	logic   dirty_q;

	// cached scaled values
	hold_t                 ev_hold_q;
	hold_t                 scan_gap_q;
	logic [FACT_BITS-1:0]  factor_q;
	eng_t                  inv_eng_q;
	logic [PROD_BITS-1:0]  prod_q;

	// item
	logic [CMD_BITS-1:0] cmd_s1;
	time_t               now_s1;
	logic [VAL_BITS-1:0] val_s1;
	logic expired_s2, live_s2, gap_ok_s2, silent_s2, dwell_s2, scan_s2;

	// result
	logic   out_changed_q;
	focus_t out_focus_q;
	time_t  out_time_q;

	cmd_t   cmd_c;
	focus_t want;
	time_t  d_change, d_int, d_idle, d_scan;
	time_t  dl_ev, dl_idle, dl_int;
	focus_t nx_focus;
	time_t  nx_deadline, nx_last_change, nx_last_idle, nx_last_int, nx_last_scan;
	eng_t   nx_eng;
	logic   nx_changed;
	logic               div_done;
	logic [Q_BITS-1:0]  quotient;

	afa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sel      (cmd.div_sel),
		.dividend (prod_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// settings port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= HOLD_RST;
			idle_ret_q   <= IDLE_RET_RST;
			scan_int_q   <= SCAN_INT_RST;
			scan_extra_q <= SCAN_EXTRA_RST;
			idle_dwell_q <= IDLE_DWELL_RST;
			gap_q        <= GAP_RST;
			int_hold_q   <= INT_HOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_HOLD:       hold_q       <= cfg_wdata;
				REG_IDLE_RET:   idle_ret_q   <= cfg_wdata;
				REG_SCAN_INT:   scan_int_q   <= cfg_wdata;
				REG_SCAN_EXTRA: scan_extra_q <= cfg_wdata;
				REG_IDLE_DWELL: idle_dwell_q <= cfg_wdata;
				REG_GAP:        gap_q        <= cfg_wdata;
				REG_INT_HOLD:   int_hold_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// time distances, all wrapping
	assign d_change = now_s1 - last_change_q;
	assign d_int    = now_s1 - last_int_q;
	assign d_idle   = now_s1 - last_idle_q;
	assign d_scan   = now_s1 - last_scan_q;
	assign dl_ev    = now_s1 + TIME_BITS'(ev_hold_q);
	assign dl_idle  = now_s1 + TIME_BITS'(idle_ret_q);
	assign dl_int   = now_s1 + TIME_BITS'(int_hold_q);

	assign cmd_c = cmd_t'(cmd_s1);
	// event codes line up with their focus codes
	assign want  = focus_t'(cmd_s1);

	always_comb begin
		nx_focus       = focus_q;
		nx_deadline    = deadline_q;
		nx_last_change = last_change_q;
		nx_last_idle   = last_idle_q;
		nx_last_int    = last_int_q;
		nx_last_scan   = last_scan_q;
		nx_eng         = eng_q;
		nx_changed     = 1'b0;
		case (cmd_c) inside
			CMD_TICK: begin
				if (expired_s2) begin
					if (gap_ok_s2) begin
						nx_focus       = F_IDLE;
						nx_deadline    = dl_idle;
						nx_last_change = now_s1;
						nx_last_idle   = now_s1;
						nx_changed     = 1'b1;
					end
				end else if (silent_s2 && focus_q == F_IDLE && dwell_s2 && scan_s2 &&
						gap_ok_s2) begin
					nx_last_scan   = now_s1;
					nx_focus       = F_INTERNAL;
					nx_deadline    = dl_int;
					nx_last_change = now_s1;
					nx_changed     = 1'b1;
				end
			end
			CMD_TOUCH, CMD_VOICE, CMD_VISION, CMD_POWER: begin
				if (cmd_c == CMD_TOUCH || cmd_c == CMD_VOICE)
					nx_last_int = now_s1;
				if (focus_q == want && live_s2) begin
					nx_deadline = dl_ev;
				end else if (!(cmd_c == CMD_VISION && focus_q != want && !gap_ok_s2)) begin
					nx_focus       = want;
					nx_deadline    = dl_ev;
					nx_last_change = now_s1;
					nx_changed     = 1'b1;
				end
			end
			CMD_ENGAGE: begin
				nx_eng = (val_s1 > VAL_BITS'(ENG_FULL)) ? ENG_FULL : ENG_BITS'(val_s1);
			end
			CMD_IDLE: begin
				if (focus_q == F_IDLE)
					nx_deadline = dl_idle;
			end
			default: ;
		endcase
	end

	// focus state and recompute flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_q       <= F_IDLE;
			deadline_q    <= TIME_BITS'(IDLE_RET_RST);
			last_change_q <= '0;
			last_idle_q   <= '0;
			last_int_q    <= '0;
			last_scan_q   <= '0;
			eng_q         <= ENG_RST;
			dirty_q       <= 1'b1;
		end else begin
			if (cmd.apply) begin
				focus_q       <= nx_focus;
				deadline_q    <= nx_deadline;
				last_change_q <= nx_last_change;
				last_idle_q   <= nx_last_idle;
				last_int_q    <= nx_last_int;
				last_scan_q   <= nx_last_scan;
				eng_q         <= nx_eng;
			end
			if (cfg_wr_en || (cmd.apply && cmd_c == CMD_ENGAGE))
				dirty_q <= 1'b1;
			else if (cmd.dirty_clr)
				dirty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1 <= in_item.cmd;
			now_s1 <= TIME_BITS'(in_item.now_ms);
			val_s1 <= in_item.value;
		end
		if (cmd.eval) begin
			expired_s2 <= (focus_q != F_IDLE) && (now_s1 >= deadline_q);
			live_s2    <= now_s1 < deadline_q;
			gap_ok_s2  <= CMP_BITS'(d_change) >= CMP_BITS'(gap_q);
			silent_s2  <= CMP_BITS'(d_int) >= CMP_BITS'(idle_ret_q);
			dwell_s2   <= CMP_BITS'(d_idle) >= CMP_BITS'(idle_dwell_q);
			scan_s2    <= CMP_BITS'(d_scan) >= CMP_BITS'(scan_gap_q);
		end
		if (cmd.apply) begin
			out_changed_q <= nx_changed;
			out_focus_q   <= nx_focus;
			out_time_q    <= nx_last_change;
		end
		// scaled hold and scan interval, refreshed after reset, engagement or settings change
		if (cmd.fact) begin
			factor_q  <= EV_BASE + FACT_BITS'(eng_q) * EV_SLOPE;
			inv_eng_q <= ENG_FULL - eng_q;
		end
		if (cmd.mul_ev)
			prod_q <= PROD_BITS'(hold_q) * PROD_BITS'(factor_q);
		else if (cmd.mul_scan)
			prod_q <= PROD_BITS'(inv_eng_q) * PROD_BITS'(scan_extra_q);
		if (cmd.ev_load)
			ev_hold_q <= HOLD_BITS'(quotient);
		if (cmd.gap_load)
			scan_gap_q <= HOLD_BITS'(scan_int_q) + HOLD_BITS'(quotient);
	end

	assign status.dirty    = dirty_q;
	assign status.div_done = div_done;

	assign out_item.changed     = out_changed_q;
	assign out_item.focus       = out_focus_q;
	assign out_item.change_time = 32'(out_time_q);
endmodule

// ===== rtl/afa_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afa_ctrl
// Sequencer: item handshake, evaluate/apply steps and hold recompute.
// ---------------------------------------------------------------------------
module afa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  afa_pkg::dp_status_t  status,
	output afa_pkg::ctrl_cmd_t   cmd
);
	import afa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel = DIV_EV;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !status.dirty;
				if (status.dirty) begin
					cmd.dirty_clr = 1'b1;
					cmd.fact      = 1'b1;
					state_d       = S_MUL_EV;
				end else if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				// commit only when the result register can take the item
				if (out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_MUL_EV: begin
				cmd.mul_ev = 1'b1;
				state_d    = S_DIV_EV_GO;
			end
			S_DIV_EV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_EV;
				state_d       = S_DIV_EV_WAIT;
			end
			S_DIV_EV_WAIT: begin
				if (status.div_done) begin
					cmd.ev_load = 1'b1;
					state_d     = S_MUL_SCAN;
				end
			end
			S_MUL_SCAN: begin
				cmd.mul_scan = 1'b1;
				state_d      = S_DIV_SCAN_GO;
			end
			S_DIV_SCAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SCAN;
				state_d       = S_DIV_SCAN_WAIT;
			end
			S_DIV_SCAN_WAIT: begin
				if (status.div_done) begin
					cmd.gap_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.apply)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
endmodule

// ===== rtl/attention_focus_arbiter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// attention_focus_arbiter
// Arbitrates one attention focus from timestamped events and ticks.
// ---------------------------------------------------------------------------
// item: valid/ready input carrying cmd, now_ms and value. result: valid/ready
// output carrying changed, focus and change_time; every item gives exactly
// one result. Settings are written through cfg_wr_en/cfg_idx/cfg_wdata while
// the block has nothing in flight.
// An item is captured at the accepting edge, compared in the next cycle and
// committed once the result register can take it; no new item is accepted
// until the previous one has committed. The result sits in an output register;
// the next item is accepted and compared while it waits, and commits once the
// receiver has taken the previous result.
// The event hold and scan interval are cached: after reset, after any
// settings write and after an engagement item, two reciprocal-multiply
// divisions refresh them and item.ready stays low until both are done.
// Reset is asynchronous: focus returns to idle, settings to their defaults
// and the refresh above starts at once.
// ---------------------------------------------------------------------------
module attention_focus_arbiter (
	input  logic                          clk,
	input  logic                          arst_n,
	afa_stream_if.sink                    item,
	afa_stream_if.source                  result,
	input  logic                          cfg_wr_en,
	input  logic [afa_pkg::IDX_BITS-1:0]  cfg_idx,
	input  logic [afa_pkg::CFG_BITS-1:0]  cfg_wdata
);
	import afa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	in_item_t   in_item;
	out_item_t  out_item;

	assign in_item     = item.data;
	assign result.data = out_item;

	afa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	afa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the attention focus arbiter: directed event
// sequences, then random timelines under several settings and stall patterns,
// with every result checked against a focus predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb;
	import afa_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	logic                cfg_wr_en;
	logic [IDX_BITS-1:0] cfg_idx;
	cfg_t                cfg_wdata;

	afa_stream_if #(.T(in_item_t))  item_ch ();
	afa_stream_if #(.T(out_item_t)) result_ch ();

	attention_focus_arbiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	cfg_t   settings [0:6];
	focus_t cur_focus;
	time_t  deadline;
	time_t  changed_at;
	time_t  idle_since;
	time_t  touched_at;
	time_t  scanned_at;
	eng_t   engagement;
	bit     focus_moved;

	out_item_t pending_reports [$];
	out_item_t oldest_report;
	int        error_count;
	int        send_idle_pct;
	int        recv_idle_pct;
	time_t     stream_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_error(string msg);
		$display("%0t: %s", $time, msg);
		error_count++;
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic void claim_focus(focus_t want, time_t now, logic [63:0] hold);
		bit urgent;
		urgent = (want == F_TOUCH) || (want == F_VOICE) || (want == F_POWER);
		if (cur_focus == want && now < deadline) begin
			deadline = time_t'(64'(now) + hold);
			return;
		end
		if (!urgent && cur_focus != want && time_t'(now - changed_at) < settings[REG_GAP])
			return;
		cur_focus  = want;
		deadline   = time_t'(64'(now) + hold);
		changed_at = now;
		if (want == F_IDLE)
			idle_since = now;
		focus_moved = 1'b1;
	endfunction

	function automatic void tick_focus(time_t now);
		logic [63:0] scan_gap;
		scan_gap = 64'(settings[REG_SCAN_INT]) +
			(64'(ENG_FULL - engagement) * 64'(settings[REG_SCAN_EXTRA])) / 64'd1000;
		if (cur_focus != F_IDLE && now >= deadline) begin
			claim_focus(F_IDLE, now, 64'(settings[REG_IDLE_RET]));
			return;
		end
		if (time_t'(now - touched_at) < settings[REG_IDLE_RET])
			return;
		if (cur_focus == F_IDLE && time_t'(now - idle_since) >= settings[REG_IDLE_DWELL] &&
				64'(time_t'(now - scanned_at)) >= scan_gap &&
				time_t'(now - changed_at) >= settings[REG_GAP]) begin
			scanned_at = now;
			claim_focus(F_INTERNAL, now, 64'(settings[REG_INT_HOLD]));
		end
	endfunction

	function automatic out_item_t next_focus_report(in_item_t it);
		logic [63:0] ev_hold;
		time_t       now;
		out_item_t   rep;
		now     = it.now_ms;
		ev_hold = (64'(settings[REG_HOLD]) * (64'd850000 + 64'd450 * 64'(engagement))) /
			64'd1000000;
		focus_moved = 1'b0;
		case (cmd_t'(it.cmd))
			CMD_TICK: tick_focus(now);
			CMD_TOUCH: begin
				touched_at = now;
				claim_focus(F_TOUCH, now, ev_hold);
			end
			CMD_VOICE: begin
				touched_at = now;
				claim_focus(F_VOICE, now, ev_hold);
			end
			CMD_VISION: claim_focus(F_VISION, now, ev_hold);
			CMD_POWER: claim_focus(F_POWER, now, ev_hold);
			CMD_ENGAGE: engagement = (it.value > 16'(ENG_FULL)) ? ENG_FULL : eng_t'(it.value);
			CMD_IDLE: begin
				if (cur_focus == F_IDLE)
					deadline = time_t'(64'(now) + 64'(settings[REG_IDLE_RET]));
			end
			default: ;
		endcase
		rep.changed     = focus_moved;
		rep.focus       = cur_focus;
		rep.change_time = changed_at;
		return rep;
	endfunction

	function automatic void restore_power_on();
		settings[REG_HOLD]       = HOLD_RST;
		settings[REG_IDLE_RET]   = IDLE_RET_RST;
		settings[REG_SCAN_INT]   = SCAN_INT_RST;
		settings[REG_SCAN_EXTRA] = SCAN_EXTRA_RST;
		settings[REG_IDLE_DWELL] = IDLE_DWELL_RST;
		settings[REG_GAP]        = GAP_RST;
		settings[REG_INT_HOLD]   = INT_HOLD_RST;
		cur_focus  = F_IDLE;
		deadline   = time_t'(IDLE_RET_RST);
		changed_at = '0;
		idle_since = '0;
		touched_at = '0;
		scanned_at = '0;
		engagement = ENG_RST;
	endfunction

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
			pending_reports.push_back(next_focus_report(item_ch.data));
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				report_error("result with no item waiting for it");
			end else begin
				oldest_report = pending_reports.pop_front();
				if (result_ch.data.changed !== oldest_report.changed)
					report_error($sformatf("changed mismatch: got %0b, want %0b",
						result_ch.data.changed, oldest_report.changed));
				if (result_ch.data.focus !== oldest_report.focus)
					report_error($sformatf("focus mismatch: got %0d, want %0d",
						result_ch.data.focus, oldest_report.focus));
				if (result_ch.data.change_time !== oldest_report.change_time)
					report_error($sformatf("change_time mismatch: got %0h, want %0h",
						result_ch.data.change_time, oldest_report.change_time));
			end
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_item(cmd_t c, time_t now, logic [VAL_BITS-1:0] v);
		in_item_t it;
		it.cmd    = c;
		it.now_ms = now;
		it.value  = v;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_setting(logic [IDX_BITS-1:0] idx, cfg_t v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		if (idx <= REG_INT_HOLD)
			settings[idx] = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic program_settings(cfg_t hold, cfg_t idle_ret, cfg_t scan, cfg_t extra,
			cfg_t dwell, cfg_t gap, cfg_t int_hold);
		write_setting(REG_HOLD, hold);
		write_setting(REG_IDLE_RET, idle_ret);
		write_setting(REG_SCAN_INT, scan);
		write_setting(REG_SCAN_EXTRA, extra);
		write_setting(REG_IDLE_DWELL, dwell);
		write_setting(REG_GAP, gap);
		write_setting(REG_INT_HOLD, int_hold);
	endtask

	// random timeline: mostly forward-moving time with a mix of events and ticks,
	// some items with arbitrary timestamps and commands
	task automatic run_timeline(int count, int step_max);
		cmd_t                c;
		logic [VAL_BITS-1:0] v;
		time_t               now;
		int                  r;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained();
			if ($urandom_range(99) < 12) begin
				c   = cmd_t'($urandom_range(7));
				now = $urandom;
				v   = VAL_BITS'($urandom);
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					stream_ms += $urandom_range(step_max / 8);
				else if (r < 95)
					stream_ms += $urandom_range(step_max);
				else
					stream_ms += $urandom_range(step_max * 4);
				now = stream_ms;
				r   = $urandom_range(99);
				if (r < 45)      c = CMD_TICK;
				else if (r < 55) c = CMD_TOUCH;
				else if (r < 63) c = CMD_VOICE;
				else if (r < 71) c = CMD_VISION;
				else if (r < 77) c = CMD_POWER;
				else if (r < 84) c = CMD_ENGAGE;
				else if (r < 92) c = CMD_IDLE;
				else             c = CMD_NOP;
				if (c == CMD_ENGAGE && $urandom_range(9) != 0)
					v = VAL_BITS'($urandom_range(1000));
				else
					v = VAL_BITS'($urandom);
			end
			send_item(c, now, v);
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_defaults();
		send_item(CMD_TICK, 32'd0, 16'h0000);           // zero timestamp right after reset
		send_item(CMD_VISION, 32'd100, 16'hFFFF);       // inside the switch gap: refused
		send_item(CMD_TOUCH, 32'd150, 16'h0000);        // preempts at once
		send_item(CMD_TOUCH, 32'd1000, 16'h0000);       // same live focus: deadline only
		send_item(CMD_VISION, 32'd1100, 16'h0000);
		send_item(CMD_ENGAGE, 32'd1150, 16'hFFFF);      // saturates to full engagement
		send_item(CMD_VOICE, 32'd1200, 16'h0000);
		send_item(CMD_IDLE, 32'd1300, 16'h0000);        // not idle: no effect
		send_item(CMD_ENGAGE, 32'd1350, 16'h0000);
		send_item(CMD_TICK, 32'd3000, 16'h0000);
		send_item(CMD_TICK, 32'd7000, 16'h0000);        // voice hold expired
		send_item(CMD_IDLE, 32'd7100, 16'h0000);        // idle: deadline moves
		send_item(CMD_TICK, 32'd40000, 16'h0000);       // silence long enough: scan
		send_item(CMD_VISION, 32'd40100, 16'h0000);
		send_item(CMD_TICK, 32'd42000, 16'h0000);
		send_item(CMD_ENGAGE, 32'd42100, 16'd1000);
		send_item(CMD_ENGAGE, 32'd42200, 16'd1001);
		send_item(CMD_POWER, 32'hFFFF_FE00, 16'h0000);  // deadline wraps past zero
		send_item(CMD_TICK, 32'hFFFF_FF80, 16'h0000);   // plain compare sees it expired
		send_item(CMD_NOP, 32'h1234_5678, 16'hFFFF);
		send_item(CMD_TOUCH, 32'hFFFF_FFFF, 16'hAAAA);
		send_item(CMD_VOICE, 32'hFFFF_FFFF, 16'h5555);
		wait_drained();
	endtask

	task automatic test_expiry_within_gap();
		write_setting(REG_HOLD, cfg_t'(0));
		write_setting(REG_UNUSED, cfg_t'(20'hFFFFF));   // unmapped index: nothing changes
		send_item(CMD_TOUCH, 32'd50000, 16'h0000);
		send_item(CMD_TICK, 32'd50010, 16'h0000);       // expired, but too soon after touch
		send_item(CMD_TICK, 32'd50400, 16'h0000);
		send_item(CMD_VISION, 32'd50500, 16'h0000);     // gap still the default one
		wait_drained();
	endtask

	task automatic test_short_holds();
		program_settings(cfg_t'(500), cfg_t'(1000), cfg_t'(2000), cfg_t'(1000),
			cfg_t'(200), cfg_t'(50), cfg_t'(300));
		stream_ms = 32'd100000;
		run_timeline(380, 600);
	endtask

	task automatic test_zero_settings();
		program_settings('0, '0, '0, '0, '0, '0, '0);
		stream_ms = 32'h8000_0000;
		run_timeline(250, 50);
	endtask

	task automatic test_max_settings();
		program_settings('1, '1, '1, '1, '1, '1, '1);
		stream_ms = 32'hFFF0_0000;
		run_timeline(150, 400000);
	endtask

	task automatic test_mixed_settings();
		for (int p = 0; p < 4; p++) begin
			program_settings(cfg_t'($urandom_range(8000)), cfg_t'($urandom_range(12000)),
				cfg_t'($urandom_range(20000)), cfg_t'($urandom_range(20000)),
				cfg_t'($urandom_range(4000)), cfg_t'($urandom_range(600)),
				cfg_t'($urandom_range(3000)));
			stream_ms = $urandom;
			run_timeline(80, 5000);
		end
	endtask

	initial begin
		error_count   = 0;
		send_idle_pct = 16;
		recv_idle_pct = 78;
		stream_ms     = '0;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_idx         = '0;
		cfg_wdata       = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		restore_power_on();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_defaults();
		test_expiry_within_gap();
		test_short_holds();

		send_idle_pct = 78;
		recv_idle_pct = 16;
		test_zero_settings();
		test_max_settings();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_mixed_settings();

		repeat (20) @(posedge clk);
		if (pending_reports.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_reports.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
